>>> sv/depth_normal_jacobian_assert.svh
// Assertion macros for the checker file.
`ifndef DEPTH_NORMAL_JACOBIAN_ASSERT_SVH
`define DEPTH_NORMAL_JACOBIAN_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define DNJ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Implication with a fixed delay in cycles.
`define DNJ_ASSERT_DLY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("delayed implication check failed");

`endif

>>> sv/dnj_pkg.sv
// ----------------------------------------------------------------------------
// dnj_pkg
// Types, constants and saturating helpers for the normal Jacobian pipeline.
// ----------------------------------------------------------------------------
package dnj_pkg;

  localparam int unsigned FieldW      = 48;
  localparam int unsigned WordW       = 64;
  localparam int unsigned FracW       = 32;
  localparam int unsigned DivNumW     = WordW + FracW;
  localparam int unsigned SqrtRootW   = 48;
  localparam int unsigned FocalW      = 32;
  localparam int unsigned FocalFracW  = 16;

  localparam logic [FocalW-1:0] FocalResetC = 32'd65536000;
  localparam logic [FocalW-1:0] FocalMinC   = 32'd65536;

  localparam int unsigned DivStepsDefC  = 2;
  localparam int unsigned SqrtStepsDefC = 2;
  localparam int unsigned MulLatC       = 2;

  typedef struct packed {
    logic signed [FieldW-1:0] pixel_x;
    logic signed [FieldW-1:0] pixel_y;
    logic signed [FieldW-1:0] depth;
    logic signed [FieldW-1:0] depth_slope_x;
    logic signed [FieldW-1:0] depth_slope_y;
    logic signed [FieldW-1:0] basis_depth;
    logic signed [FieldW-1:0] basis_slope_x;
    logic signed [FieldW-1:0] basis_slope_y;
  } dnj_req_t;

  typedef struct packed {
    logic signed [FieldW-1:0] normal_x_deriv;
    logic signed [FieldW-1:0] normal_y_deriv;
    logic signed [FieldW-1:0] normal_z_deriv;
    logic                     degenerate;
  } dnj_res_t;

  localparam logic signed [WordW-1:0] MaxC = {1'b0, {(WordW-1){1'b1}}};
  localparam logic signed [WordW-1:0] MinC = {1'b1, {(WordW-1){1'b0}}};

  function automatic logic [WordW-1:0] magn(input logic signed [WordW-1:0] v);
    magn = v[WordW-1] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic signed [WordW-1:0] sadd(input logic signed [WordW-1:0] a,
                                                   input logic signed [WordW-1:0] b);
    logic signed [WordW-1:0] s;
    s = a + b;
    if (a[WordW-1] == b[WordW-1] && s[WordW-1] != a[WordW-1]) begin
      sadd = a[WordW-1] ? MinC : MaxC;
    end else begin
      sadd = s;
    end
  endfunction

  function automatic logic signed [WordW-1:0] ssub(input logic signed [WordW-1:0] a,
                                                   input logic signed [WordW-1:0] b);
    logic signed [WordW-1:0] s;
    s = a - b;
    if (a[WordW-1] != b[WordW-1] && s[WordW-1] != a[WordW-1]) begin
      ssub = a[WordW-1] ? MinC : MaxC;
    end else begin
      ssub = s;
    end
  endfunction

  // Signed result from a sign and a 96-bit magnitude, clamped to 64 bits.
  function automatic logic signed [WordW-1:0] sat96(input logic neg,
                                                    input logic [DivNumW-1:0] m);
    if (neg) begin
      if (m[DivNumW-1:WordW] != '0 || m[WordW-1]) sat96 = MinC;
      else sat96 = ~m[WordW-1:0] + 64'd1;
    end else begin
      if (m[DivNumW-1:WordW-1] != '0) sat96 = MaxC;
      else sat96 = m[WordW-1:0];
    end
  endfunction

  function automatic logic signed [FieldW-1:0] sat48(input logic signed [WordW-1:0] v);
    if (v[WordW-1] && v[WordW-2:FieldW-1] != {(WordW-FieldW){1'b1}}) begin
      sat48 = {1'b1, {(FieldW-1){1'b0}}};
    end else if (!v[WordW-1] && v[WordW-2:FieldW-1] != '0) begin
      sat48 = {1'b0, {(FieldW-1){1'b1}}};
    end else begin
      sat48 = v[FieldW-1:0];
    end
  endfunction

endpackage

>>> sv/dnj_delay.sv
// ----------------------------------------------------------------------------
// dnj_delay
// Fixed-length shift line that keeps operands aligned with the pipeline.
// ----------------------------------------------------------------------------
module dnj_delay #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1
) (
  input  logic             clk_i,
  input  logic [Width-1:0] d_i,
  output logic [Width-1:0] q_o
);

  logic [Width-1:0] tap_q [Depth];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int i = 1; i < Depth; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign q_o = tap_q[Depth-1];

endmodule

>>> sv/dnj_mul.sv
// ----------------------------------------------------------------------------
// dnj_mul
// Two-stage signed fixed-point multiply: four 32x32 partial products, then
// sum, drop 32 fraction bits and clamp to 64 bits.
// ----------------------------------------------------------------------------
module dnj_mul
  import dnj_pkg::*;
(
  input  logic                    clk_i,
  input  logic signed [WordW-1:0] a_i,
  input  logic signed [WordW-1:0] b_i,
  output logic signed [WordW-1:0] p_o
);

  localparam int unsigned HalfW = WordW / 2;

  logic [WordW-1:0]   ma, mb;
  logic [WordW-1:0]   ll_q, lh_q, hl_q, hh_q;
  logic               neg_q;
  logic [2*WordW-1:0] sum;
  logic [WordW-1:0]   p_q;

  assign ma = magn(a_i);
  assign mb = magn(b_i);

  always_ff @(posedge clk_i) begin
    ll_q  <= ma[HalfW-1:0]     * mb[HalfW-1:0];
    lh_q  <= ma[HalfW-1:0]     * mb[WordW-1:HalfW];
    hl_q  <= ma[WordW-1:HalfW] * mb[HalfW-1:0];
    hh_q  <= ma[WordW-1:HalfW] * mb[WordW-1:HalfW];
    neg_q <= a_i[WordW-1] ^ b_i[WordW-1];
  end

  assign sum = {64'd0, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0}
             + {hh_q, 64'd0};

  always_ff @(posedge clk_i) begin
    p_q <= sat96(neg_q, sum[2*WordW-1:FracW]);
  end

  assign p_o = p_q;

endmodule

>>> sv/dnj_div.sv
// ----------------------------------------------------------------------------
// dnj_div
// Pipelined restoring divider: (num * 2^32) / den, truncated, clamped.
// A zero divisor gives zero.
// ----------------------------------------------------------------------------
module dnj_div
  import dnj_pkg::*;
#(
  parameter int unsigned StepsPerStage = DivStepsDefC
) (
  input  logic                    clk_i,
  input  logic signed [WordW-1:0] num_i,
  input  logic signed [WordW-1:0] den_i,
  output logic signed [WordW-1:0] quo_o
);

  localparam int unsigned NumStages = DivNumW / StepsPerStage;

  logic [WordW-1:0]   rem_q [NumStages+1];
  logic [DivNumW-1:0] num_q [NumStages+1];
  logic [DivNumW-1:0] quo_q [NumStages+1];
  logic [WordW-1:0]   den_q [NumStages+1];
  logic               neg_q [NumStages+1];
  logic               dz_q  [NumStages+1];
  logic [WordW-1:0]   res_q;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    num_q[0] <= {magn(num_i), {FracW{1'b0}}};
    quo_q[0] <= '0;
    den_q[0] <= magn(den_i);
    neg_q[0] <= num_i[WordW-1] ^ den_i[WordW-1];
    dz_q[0]  <= (den_i == '0);
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [WordW-1:0]   rem_d;
    logic [DivNumW-1:0] num_d, quo_d;

    always_comb begin
      rem_d = rem_q[s];
      num_d = num_q[s];
      quo_d = quo_q[s];
      for (int k = 0; k < StepsPerStage; k++) begin
        // remainder stays below the divisor, so its top bit is free
        rem_d = {rem_d[WordW-2:0], num_d[DivNumW-1]};
        num_d = {num_d[DivNumW-2:0], 1'b0};
        quo_d = {quo_d[DivNumW-2:0], 1'b0};
        if (rem_d >= den_q[s]) begin
          rem_d    = rem_d - den_q[s];
          quo_d[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= rem_d;
      num_q[s+1] <= num_d;
      quo_q[s+1] <= quo_d;
      den_q[s+1] <= den_q[s];
      neg_q[s+1] <= neg_q[s];
      dz_q[s+1]  <= dz_q[s];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= dz_q[NumStages] ? '0 : sat96(neg_q[NumStages], quo_q[NumStages]);
  end

  assign quo_o = res_q;

endmodule

>>> sv/dnj_sqrt.sv
// ----------------------------------------------------------------------------
// dnj_sqrt
// Pipelined digit-by-digit square root: floor(sqrt(t * 2^32)) for t >= 0.
// ----------------------------------------------------------------------------
module dnj_sqrt
  import dnj_pkg::*;
#(
  parameter int unsigned StepsPerStage = SqrtStepsDefC
) (
  input  logic                    clk_i,
  input  logic signed [WordW-1:0] t_i,
  output logic signed [WordW-1:0] root_o
);

  localparam int unsigned NumStages = SqrtRootW / StepsPerStage;
  localparam int unsigned RemW      = SqrtRootW + 4;

  logic [RemW-1:0]      rem_q  [NumStages+1];
  logic [SqrtRootW-1:0] root_q [NumStages+1];
  logic [DivNumW-1:0]   rad_q  [NumStages+1];
  logic [WordW-1:0]     res_q;

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= '0;
    root_q[0] <= '0;
    rad_q[0]  <= {t_i[WordW-1] ? '0 : t_i, {FracW{1'b0}}};
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    logic [RemW-1:0]      rem_d, trial;
    logic [SqrtRootW-1:0] root_d;
    logic [DivNumW-1:0]   rad_d;

    always_comb begin
      rem_d  = rem_q[s];
      root_d = root_q[s];
      rad_d  = rad_q[s];
      trial  = '0;
      for (int k = 0; k < StepsPerStage; k++) begin
        rem_d = {rem_d[RemW-3:0], rad_d[DivNumW-1:DivNumW-2]};
        rad_d = {rad_d[DivNumW-3:0], 2'b00};
        trial = {2'b00, root_d, 2'b01};
        if (rem_d >= trial) begin
          rem_d  = rem_d - trial;
          root_d = {root_d[SqrtRootW-2:0], 1'b1};
        end else begin
          root_d = {root_d[SqrtRootW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1]  <= rem_d;
      root_q[s+1] <= root_d;
      rad_q[s+1]  <= rad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= {{(WordW-SqrtRootW){1'b0}}, root_q[NumStages]};
  end

  assign root_o = res_q;

endmodule

>>> sv/depth_normal_jacobian.sv
// ----------------------------------------------------------------------------
// depth_normal_jacobian
// Derivative of the unnormalised surface normal with respect to one basis
// coefficient, for one pixel per request.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_i and raise start_i; the request is taken at
//   any edge where start_i is high and busy_o is low. busy_o stays low, so a
//   new request may be issued every cycle.
//   Result channel: done_o pulses for one cycle with res_o valid; the
//   receiver must take it then, there is no back-pressure.
//   A request passes through three divider pipelines, one square-root
//   pipeline and three multipliers in series. Throughput is one request
//   per cycle, as nothing in the pipeline stalls.
//   focal_length_i is written when focal_length_we_i is high; write it only
//   while no request is in flight.
//   Reset clears the in-flight valid bits (requests in flight are dropped)
//   and loads the focal length with 1000.0.
// ----------------------------------------------------------------------------
module depth_normal_jacobian
  import dnj_pkg::*;
#(
  parameter int unsigned DivStepsPerStage  = DivStepsDefC,
  parameter int unsigned SqrtStepsPerStage = SqrtStepsDefC
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  dnj_req_t          req_i,
  output logic              done_o,
  output dnj_res_t          res_o,
  input  logic              focal_length_we_i,
  input  logic [FocalW-1:0] focal_length_i
);

  localparam int unsigned DivLat  = DivNumW / DivStepsPerStage + 2;
  localparam int unsigned SqrtLat = SqrtRootW / SqrtStepsPerStage + 2;
  localparam int unsigned TA      = MulLatC + 1;
  localparam int unsigned TG      = TA + DivLat;
  localparam int unsigned TGG     = TG + MulLatC;
  localparam int unsigned TT      = TGG + 1;
  localparam int unsigned TN      = TT + SqrtLat;
  localparam int unsigned TNP     = TN + DivLat;
  localparam int unsigned TP      = TNP + MulLatC;
  localparam int unsigned TD      = TP + 1;
  localparam int unsigned TQ      = TD + DivLat;
  localparam int unsigned Latency = TQ + 1;

  logic [FocalW-1:0] focal_q;
  logic [Latency-1:0] vld_q;
  logic               req_ok;

  logic signed [WordW-1:0] x, y, w, dx, dy, wp, dxp, dyp, f;
  logic [FocalW-1:0]       fl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_q <= FocalResetC;
      vld_q   <= '0;
    end else begin
      if (focal_length_we_i) begin
        focal_q <= focal_length_i;
      end
      vld_q <= {vld_q[Latency-2:0], req_ok};
    end
  end

  assign busy_o = 1'b0;
  assign req_ok = start_i && !busy_o;

  assign fl = (focal_q < FocalMinC) ? FocalMinC : focal_q;
  assign f  = {{(WordW-FocalW-FocalFracW){1'b0}}, fl, {FocalFracW{1'b0}}};

  assign x   = WordW'(req_i.pixel_x);
  assign y   = WordW'(req_i.pixel_y);
  assign w   = WordW'(req_i.depth);
  assign dx  = WordW'(req_i.depth_slope_x);
  assign dy  = WordW'(req_i.depth_slope_y);
  assign wp  = WordW'(req_i.basis_depth);
  assign dxp = WordW'(req_i.basis_slope_x);
  assign dyp = WordW'(req_i.basis_slope_y);

  // Front products
  logic signed [WordW-1:0] xdx, ydy, xdxp, ydyp, dxdx, dydy, dxdxp, dydyp;

  dnj_mul u_mul_xdx   (.clk_i, .a_i(x),  .b_i(dx),  .p_o(xdx));
  dnj_mul u_mul_ydy   (.clk_i, .a_i(y),  .b_i(dy),  .p_o(ydy));
  dnj_mul u_mul_xdxp  (.clk_i, .a_i(x),  .b_i(dxp), .p_o(xdxp));
  dnj_mul u_mul_ydyp  (.clk_i, .a_i(y),  .b_i(dyp), .p_o(ydyp));
  dnj_mul u_mul_dxdx  (.clk_i, .a_i(dx), .b_i(dx),  .p_o(dxdx));
  dnj_mul u_mul_dydy  (.clk_i, .a_i(dy), .b_i(dy),  .p_o(dydy));
  dnj_mul u_mul_dxdxp (.clk_i, .a_i(dx), .b_i(dxp), .p_o(dxdxp));
  dnj_mul u_mul_dydyp (.clk_i, .a_i(dy), .b_i(dyp), .p_o(dydyp));

  logic signed [WordW-1:0] w_m, wp_m;

  dnj_delay #(.Width(WordW), .Depth(MulLatC)) u_dly_w  (.clk_i, .d_i(w),  .q_o(w_m));
  dnj_delay #(.Width(WordW), .Depth(MulLatC)) u_dly_wp (.clk_i, .d_i(wp), .q_o(wp_m));

  logic signed [WordW-1:0] a_q, ap_q;

  always_ff @(posedge clk_i) begin
    a_q  <= sadd(sadd(w_m, xdx), ydy);
    ap_q <= sadd(sadd(wp_m, xdxp), ydyp);
  end

  logic signed [WordW-1:0] g, h;

  dnj_div #(.StepsPerStage(DivStepsPerStage)) u_div_g (
    .clk_i, .num_i(a_q), .den_i(f), .quo_o(g)
  );
  dnj_div #(.StepsPerStage(DivStepsPerStage)) u_div_h (
    .clk_i, .num_i(ap_q), .den_i(f), .quo_o(h)
  );

  logic signed [WordW-1:0] gg, gh;

  dnj_mul u_mul_gg (.clk_i, .a_i(g), .b_i(g), .p_o(gg));
  dnj_mul u_mul_gh (.clk_i, .a_i(g), .b_i(h), .p_o(gh));

  // Hold the slope products until g*g and g*h arrive
  logic signed [WordW-1:0] dxdx_d, dydy_d, dxdxp_d, dydyp_d;

  dnj_delay #(.Width(WordW), .Depth(TGG - MulLatC)) u_dly_dxdx (
    .clk_i, .d_i(dxdx), .q_o(dxdx_d)
  );
  dnj_delay #(.Width(WordW), .Depth(TGG - MulLatC)) u_dly_dydy (
    .clk_i, .d_i(dydy), .q_o(dydy_d)
  );
  dnj_delay #(.Width(WordW), .Depth(TGG - MulLatC)) u_dly_dxdxp (
    .clk_i, .d_i(dxdxp), .q_o(dxdxp_d)
  );
  dnj_delay #(.Width(WordW), .Depth(TGG - MulLatC)) u_dly_dydyp (
    .clk_i, .d_i(dydyp), .q_o(dydyp_d)
  );

  logic signed [WordW-1:0] t_q, s_q;

  always_ff @(posedge clk_i) begin
    t_q <= sadd(sadd(dxdx_d, dydy_d), gg);
    s_q <= sadd(sadd(dxdxp_d, dydyp_d), gh);
  end

  logic signed [WordW-1:0] n, s_n, np;

  dnj_sqrt #(.StepsPerStage(SqrtStepsPerStage)) u_sqrt (
    .clk_i, .t_i(t_q), .root_o(n)
  );

  dnj_delay #(.Width(WordW), .Depth(SqrtLat)) u_dly_s (.clk_i, .d_i(s_q), .q_o(s_n));

  dnj_div #(.StepsPerStage(DivStepsPerStage)) u_div_np (
    .clk_i, .num_i(s_n), .den_i(n), .quo_o(np)
  );

  // Align operands for the back products
  logic signed [WordW-1:0] n_d, g_d, h_d, dx_d, dy_d, dxp_d, dyp_d;

  dnj_delay #(.Width(WordW), .Depth(DivLat))   u_dly_n   (.clk_i, .d_i(n),   .q_o(n_d));
  dnj_delay #(.Width(WordW), .Depth(TNP - TG)) u_dly_g   (.clk_i, .d_i(g),   .q_o(g_d));
  dnj_delay #(.Width(WordW), .Depth(TNP - TG)) u_dly_h   (.clk_i, .d_i(h),   .q_o(h_d));
  dnj_delay #(.Width(WordW), .Depth(TNP))      u_dly_dx  (.clk_i, .d_i(dx),  .q_o(dx_d));
  dnj_delay #(.Width(WordW), .Depth(TNP))      u_dly_dy  (.clk_i, .d_i(dy),  .q_o(dy_d));
  dnj_delay #(.Width(WordW), .Depth(TNP))      u_dly_dxp (.clk_i, .d_i(dxp), .q_o(dxp_d));
  dnj_delay #(.Width(WordW), .Depth(TNP))      u_dly_dyp (.clk_i, .d_i(dyp), .q_o(dyp_d));

  logic signed [WordW-1:0] dxpn, dxnp, dynp, dypn, hn, gnp;

  dnj_mul u_mul_dxpn (.clk_i, .a_i(dxp_d), .b_i(n_d), .p_o(dxpn));
  dnj_mul u_mul_dxnp (.clk_i, .a_i(dx_d),  .b_i(np),  .p_o(dxnp));
  dnj_mul u_mul_dynp (.clk_i, .a_i(dy_d),  .b_i(np),  .p_o(dynp));
  dnj_mul u_mul_dypn (.clk_i, .a_i(dyp_d), .b_i(n_d), .p_o(dypn));
  dnj_mul u_mul_hn   (.clk_i, .a_i(h_d),   .b_i(n_d), .p_o(hn));
  dnj_mul u_mul_gnp  (.clk_i, .a_i(g_d),   .b_i(np),  .p_o(gnp));

  logic signed [WordW-1:0] ex_q, ey_q, ez_q;

  always_ff @(posedge clk_i) begin
    ex_q <= ssub(dxpn, dxnp);
    ey_q <= ssub(dynp, dypn);
    ez_q <= ssub(hn, gnp);
  end

  logic signed [WordW-1:0] t_d;
  logic                    degen_d;

  dnj_delay #(.Width(WordW), .Depth(TD - TT)) u_dly_t (.clk_i, .d_i(t_q), .q_o(t_d));

  dnj_delay #(.Width(1), .Depth(DivLat)) u_dly_degen (
    .clk_i, .d_i(t_d[WordW-1] || t_d == '0), .q_o(degen_d)
  );

  logic signed [WordW-1:0] qx, qy, qz;

  dnj_div #(.StepsPerStage(DivStepsPerStage)) u_div_x (
    .clk_i, .num_i(ex_q), .den_i(t_d), .quo_o(qx)
  );
  dnj_div #(.StepsPerStage(DivStepsPerStage)) u_div_y (
    .clk_i, .num_i(ey_q), .den_i(t_d), .quo_o(qy)
  );
  dnj_div #(.StepsPerStage(DivStepsPerStage)) u_div_z (
    .clk_i, .num_i(ez_q), .den_i(t_d), .quo_o(qz)
  );

  dnj_res_t res_q;

  always_ff @(posedge clk_i) begin
    if (degen_d) begin
      res_q.normal_x_deriv <= '0;
      res_q.normal_y_deriv <= '0;
      res_q.normal_z_deriv <= '0;
    end else begin
      res_q.normal_x_deriv <= sat48(qx);
      res_q.normal_y_deriv <= sat48(qy);
      res_q.normal_z_deriv <= sat48(qz);
    end
    res_q.degenerate <= degen_d;
  end

  assign done_o = vld_q[Latency-1];
  assign res_o  = res_q;

endmodule

>>> sv/dnj_checker.sv
// ----------------------------------------------------------------------------
// dnj_port_checks
// Port-level checks on request-to-result timing and degenerate results.
// ----------------------------------------------------------------------------
`include "depth_normal_jacobian_assert.svh"

module dnj_port_checks
  import dnj_pkg::*;
#(
  parameter int unsigned Latency = 1
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start_i,
  input logic     busy_o,
  input logic     done_o,
  input dnj_res_t res_o
);

  logic res_zero;

  assign res_zero = res_o.normal_x_deriv == '0 && res_o.normal_y_deriv == '0
                 && res_o.normal_z_deriv == '0;

  `DNJ_ASSERT_DLY(a_req_gives_result, clk_i, rst_ni, start_i && !busy_o, Latency, done_o)

  `DNJ_ASSERT_IMP(a_result_has_request, clk_i, rst_ni, done_o, $past(start_i && !busy_o, Latency))

  `DNJ_ASSERT_IMP(a_degenerate_zero, clk_i, rst_ni, done_o && res_o.degenerate, res_zero)

endmodule

bind depth_normal_jacobian dnj_port_checks #(.Latency(Latency)) u_dnj_port_checks (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .res_o   (res_o)
);
